[rtl/core/sit4_pkg.sv]
// ----------------------------------------------------------------------------
// Skin influence table package
// Request and response types, command and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sit4_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountOutW = 3;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_NORM  = 2'd2;

  localparam logic [StatusW-1:0] RS_APPENDED = 3'd0;
  localparam logic [StatusW-1:0] RS_REPLACED = 3'd1;
  localparam logic [StatusW-1:0] RS_REJECTED = 3'd2;
  localparam logic [StatusW-1:0] RS_ERASED   = 3'd3;
  localparam logic [StatusW-1:0] RS_NOTFOUND = 3'd4;
  localparam logic [StatusW-1:0] RS_NORMED   = 3'd5;
  localparam logic [StatusW-1:0] RS_EMPTY    = 3'd6;

  typedef struct packed {
    logic [1:0]       command;
    logic [DataW-1:0] joint_index;
    logic [DataW-1:0] new_weight;
  } in_req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [DataW-1:0]     joint_out;
    logic [DataW-1:0]     weight_out;
    logic [CountOutW-1:0] entry_count;
    logic                 last;
  } out_rsp_t;

  typedef struct packed {
    logic               load_req;
    logic               scan_min;
    logic               scan_sum;
    logic               shift_up;
    logic               write_new;
    logic               cnt_inc;
    logic               cnt_dec;
    logic               div_start;
    logic               div_step;
    logic               div_write;
    logic               out_load;
    logic               out_entry;
    logic               out_last;
    logic [StatusW-1:0] out_status;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       empty;
    logic       joint_match;
    logic       new_min;
    logic       wins;
    logic       sum_zero;
    logic       out_free;
  } stat_t;

endpackage

[rtl/core/sit4_datapath.sv]
// ----------------------------------------------------------------------------
// Skin influence table datapath
// Holds the joint and weight tables, the entry count, the minimum and sum
// accumulators, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module sit4_datapath #(
  parameter int unsigned MAX_INFLUENCES = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sit4_pkg::ctrl_t                        ctrl_i,
  input  logic [((MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1)-1:0] idx_i,
  output sit4_pkg::stat_t                        stat_o,
  output logic [$clog2(MAX_INFLUENCES + 1)-1:0]  count_o,
  input  sit4_pkg::in_req_t                      in_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output sit4_pkg::out_rsp_t                     out_rsp_o
);

  localparam int unsigned IdxW = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
  localparam int unsigned CntW = $clog2(MAX_INFLUENCES + 1);
  localparam int unsigned SumW = sit4_pkg::DataW + $clog2(MAX_INFLUENCES);
  localparam int unsigned DW   = sit4_pkg::DataW;

  logic [DW-1:0]      joint_q  [MAX_INFLUENCES];
  logic [DW-1:0]      weight_q [MAX_INFLUENCES];
  sit4_pkg::in_req_t  req_q;
  logic [CntW-1:0]    count_q;
  logic [DW-1:0]      min_w_q;
  logic [SumW-1:0]    sum_q;
  logic [SumW-1:0]    rem_q;
  logic [DW-1:0]      nb_q;
  logic [DW-1:0]      quo_q;
  logic               out_valid_q;
  sit4_pkg::out_rsp_t out_q;

  logic [IdxW-1:0]    rd_idx;
  logic [DW-1:0]      joint_rd;
  logic [DW-1:0]      weight_rd;
  logic [SumW:0]      trial;
  logic               trial_ge;
  logic               out_free;
  logic               new_min;

  assign rd_idx    = ctrl_i.shift_up ? (idx_i + IdxW'(1)) : idx_i;
  assign joint_rd  = joint_q[rd_idx];
  assign weight_rd = weight_q[rd_idx];

  assign trial    = {rem_q, nb_q[DW-1]};
  assign trial_ge = trial >= {1'b0, sum_q};

  assign out_free = !out_valid_q || !out_stall_i;
  assign new_min  = (idx_i == '0) || (weight_rd < min_w_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_up) begin
      joint_q[idx_i]  <= joint_rd;
      weight_q[idx_i] <= weight_rd;
    end else if (ctrl_i.write_new) begin
      joint_q[idx_i]  <= req_q.joint_index;
      weight_q[idx_i] <= req_q.new_weight;
    end else if (ctrl_i.div_write) begin
      weight_q[idx_i] <= quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.cnt_inc) begin
      count_q <= count_q + CntW'(1);
    end else if (ctrl_i.cnt_dec) begin
      count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      req_q <= in_req_i;
    end
    if (ctrl_i.scan_min && new_min) begin
      min_w_q <= weight_rd;
    end
    if (ctrl_i.scan_sum) begin
      sum_q <= ((idx_i == '0) ? '0 : sum_q) + SumW'(weight_rd);
    end
    if (ctrl_i.div_start) begin
      rem_q <= SumW'(weight_rd[DW-1:1]);
      nb_q  <= {weight_rd[0], {(DW-1){1'b0}}};
      quo_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= trial_ge ? SumW'(trial - {1'b0, sum_q}) : trial[SumW-1:0];
      nb_q  <= {nb_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.status      <= ctrl_i.out_status;
      out_q.joint_out   <= ctrl_i.out_entry ? joint_rd : '0;
      out_q.weight_out  <= ctrl_i.out_entry ? weight_rd : '0;
      out_q.entry_count <= sit4_pkg::CountOutW'(count_q);
      out_q.last        <= ctrl_i.out_last;
    end
  end

  assign stat_o.command     = req_q.command;
  assign stat_o.full        = count_q == CntW'(MAX_INFLUENCES);
  assign stat_o.empty       = count_q == '0;
  assign stat_o.joint_match = joint_rd == req_q.joint_index;
  assign stat_o.new_min     = new_min;
  assign stat_o.wins        = req_q.new_weight > min_w_q;
  assign stat_o.sum_zero    = sum_q == '0;
  assign stat_o.out_free    = out_free;

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[rtl/core/sit4_controller.sv]
// ----------------------------------------------------------------------------
// Skin influence table controller
// Sequences add, erase and normalize requests over the datapath, scanning
// and shifting one entry per cycle and dividing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sit4_controller #(
  parameter int unsigned MAX_INFLUENCES = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  sit4_pkg::stat_t                        stat_i,
  input  logic [$clog2(MAX_INFLUENCES + 1)-1:0]  count_i,
  output sit4_pkg::ctrl_t                        ctrl_o,
  output logic [((MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1)-1:0] idx_o
);

  localparam int unsigned IdxW = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
  localparam int unsigned CntW = $clog2(MAX_INFLUENCES + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SCAN     = 10'b00_0000_0100,
    S_DECIDE   = 10'b00_0000_1000,
    S_SHIFT    = 10'b00_0001_0000,
    S_NLOAD    = 10'b00_0010_0000,
    S_DIV      = 10'b00_0100_0000,
    S_DIVWR    = 10'b00_1000_0000,
    S_EMIT     = 10'b01_0000_0000,
    S_RESULT   = 10'b10_0000_0000
  } state_e;

  state_e                         state_q, state_d;
  logic [IdxW-1:0]                ptr_q, ptr_d;
  logic [IdxW-1:0]                mpos_q, mpos_d;
  logic [sit4_pkg::DivCntW-1:0]   divcnt_q, divcnt_d;
  logic [sit4_pkg::StatusW-1:0]   rsp_q, rsp_d;
  logic                           is_last;

  assign is_last    = (CntW'(ptr_q) + CntW'(1)) == count_i;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    mpos_d   = mpos_q;
    divcnt_d = divcnt_q;
    rsp_d    = rsp_q;
    ctrl_o   = '0;
    idx_o    = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_req = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ptr_d = '0;
        unique case (stat_i.command)
          sit4_pkg::CMD_ADD: begin
            if (!stat_i.full) begin
              idx_o            = IdxW'(count_i);
              ctrl_o.write_new = 1'b1;
              ctrl_o.cnt_inc   = 1'b1;
              rsp_d            = sit4_pkg::RS_APPENDED;
              state_d          = S_RESULT;
            end else begin
              state_d = S_SCAN;
            end
          end
          sit4_pkg::CMD_ERASE: begin
            if (stat_i.empty) begin
              rsp_d   = sit4_pkg::RS_NOTFOUND;
              state_d = S_RESULT;
            end else begin
              state_d = S_SCAN;
            end
          end
          sit4_pkg::CMD_NORM: begin
            if (stat_i.empty) begin
              rsp_d   = sit4_pkg::RS_EMPTY;
              state_d = S_RESULT;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        unique case (stat_i.command)
          sit4_pkg::CMD_ADD: begin
            ctrl_o.scan_min = 1'b1;
            if (stat_i.new_min) begin
              mpos_d = ptr_q;
            end
            if (is_last) begin
              state_d = S_DECIDE;
            end else begin
              ptr_d = ptr_q + IdxW'(1);
            end
          end
          sit4_pkg::CMD_ERASE: begin
            if (stat_i.joint_match) begin
              state_d = S_SHIFT;
            end else if (is_last) begin
              rsp_d   = sit4_pkg::RS_NOTFOUND;
              state_d = S_RESULT;
            end else begin
              ptr_d = ptr_q + IdxW'(1);
            end
          end
          default: begin
            ctrl_o.scan_sum = 1'b1;
            if (is_last) begin
              ptr_d   = '0;
              state_d = S_NLOAD;
            end else begin
              ptr_d = ptr_q + IdxW'(1);
            end
          end
        endcase
      end
      S_DECIDE: begin
        if (stat_i.wins) begin
          ptr_d   = mpos_q;
          state_d = S_SHIFT;
        end else begin
          rsp_d   = sit4_pkg::RS_REJECTED;
          state_d = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (!is_last) begin
          ctrl_o.shift_up = 1'b1;
          ptr_d           = ptr_q + IdxW'(1);
        end else begin
          if (stat_i.command == sit4_pkg::CMD_ADD) begin
            ctrl_o.write_new = 1'b1;
            rsp_d            = sit4_pkg::RS_REPLACED;
          end else begin
            ctrl_o.cnt_dec = 1'b1;
            rsp_d          = sit4_pkg::RS_ERASED;
          end
          state_d = S_RESULT;
        end
      end
      S_NLOAD: begin
        if (stat_i.sum_zero) begin
          state_d = S_EMIT;
        end else begin
          ctrl_o.div_start = 1'b1;
          divcnt_d         = '0;
          state_d          = S_DIV;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        divcnt_d        = divcnt_q + sit4_pkg::DivCntW'(1);
        if (divcnt_q == sit4_pkg::DivCntW'(sit4_pkg::DivSteps - 1)) begin
          state_d = S_DIVWR;
        end
      end
      S_DIVWR: begin
        ctrl_o.div_write = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load   = 1'b1;
          ctrl_o.out_entry  = 1'b1;
          ctrl_o.out_status = sit4_pkg::RS_NORMED;
          ctrl_o.out_last   = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + IdxW'(1);
            state_d = S_NLOAD;
          end
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load   = 1'b1;
          ctrl_o.out_status = rsp_q;
          ctrl_o.out_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      mpos_q   <= '0;
      divcnt_q <= '0;
      rsp_q    <= sit4_pkg::RS_APPENDED;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      mpos_q   <= mpos_d;
      divcnt_q <= divcnt_d;
      rsp_q    <= rsp_d;
    end
  end

endmodule

[rtl/core/skin_influence_top4_table.sv]
// ----------------------------------------------------------------------------
// Skin influence table, top level
// Keeps up to MAX_INFLUENCES joint and weight pairs with add, erase and
// normalize requests.
// ----------------------------------------------------------------------------
// A request enters on in_req_i when in_valid_i is high and in_stall_o is low.
// The block takes one request at a time and holds in_stall_o high until the
// last response of that request has been loaded into the output register.
// Responses leave on out_rsp_o when out_valid_o is high and out_stall_i is
// low; the output register lets the next request enter while a response
// still waits.
// Add on a table that is not full and requests on an empty table go from
// dispatch straight to the result. Add on a full table and erase scan the
// held entries one per cycle and close gaps one entry per cycle. Normalize
// sums the entries, then divides each entry with a restoring divider that
// produces one quotient bit per cycle; a zero sum skips the division.
// Stalls on the output side hold the block in its emit and result states.
// Reset empties the table and clears out_valid_o; entry contents are
// not cleared. Unused command codes are dropped without a response.
// ----------------------------------------------------------------------------
module skin_influence_top4_table #(
  parameter int unsigned MAX_INFLUENCES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sit4_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sit4_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
  localparam int unsigned CntW = $clog2(MAX_INFLUENCES + 1);

  sit4_pkg::ctrl_t ctrl;
  sit4_pkg::stat_t stat;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] count;

  sit4_controller #(
    .MAX_INFLUENCES(MAX_INFLUENCES)
  ) u_controller (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .count_i   (count),
    .ctrl_o    (ctrl),
    .idx_o     (idx)
  );

  sit4_datapath #(
    .MAX_INFLUENCES(MAX_INFLUENCES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .idx_i      (idx),
    .stat_o     (stat),
    .count_o    (count),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.last |-> out_rsp_o.status == sit4_pkg::RS_NORMED)
    else $error("Only normalized entries may be followed by more responses.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("A response was loaded over one that is still waiting.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(MAX_INFLUENCES))
    else $error("The entry count exceeds the table size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> in_stall_o)
    else $error("A response was produced while requests were being taken.");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Skin influence table testbench
// Directed and random add, erase and normalize requests go against a
// behavioral copy of the four-entry influence table. Each response is checked
// field by field, in order. The sender idles in bursts and the receiver
// stalls on its own pattern, with one long hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb;
  import sit4_pkg::*;

  localparam int          MaxInf      = 4;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [1:0]  CmdUnused   = 2'd3;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  logic [DataW-1:0] mdl_joint  [MaxInf];
  logic [DataW-1:0] mdl_weight [MaxInf];
  int               mdl_count   = 0;
  out_rsp_t         table_rsp_q [$];
  out_rsp_t         exp_rsp;
  int unsigned      err_cnt     = 0;
  int unsigned      burst_left  = 0;
  int unsigned      hold_reqs   = 0;

  skin_influence_top4_table #(
    .MAX_INFLUENCES(MaxInf)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_rsp_t make_rsp(input logic [StatusW-1:0] status,
                                        input logic [DataW-1:0] joint,
                                        input logic [DataW-1:0] weight,
                                        input logic last);
    out_rsp_t rsp;
    rsp.status      = status;
    rsp.joint_out   = joint;
    rsp.weight_out  = weight;
    rsp.entry_count = CountOutW'(mdl_count);
    rsp.last        = last;
    return rsp;
  endfunction

  function automatic void queue_rsp(input out_rsp_t rsp);
    table_rsp_q = {table_rsp_q, rsp};
  endfunction

  function automatic void remove_entry(input int pos);
    for (int i = pos; i + 1 < mdl_count; i++) begin
      mdl_joint[i]  = mdl_joint[i + 1];
      mdl_weight[i] = mdl_weight[i + 1];
    end
    mdl_count--;
  endfunction

  function automatic void append_entry(input logic [DataW-1:0] joint,
                                       input logic [DataW-1:0] weight);
    mdl_joint[mdl_count]  = joint;
    mdl_weight[mdl_count] = weight;
    mdl_count++;
  endfunction

  task automatic predict_table_rsp(input in_req_t req);
    int               min_pos;
    logic [DataW-1:0] min_w;
    logic [17:0]      weight_sum;
    logic [31:0]      quo;
    bit               found;
    case (req.command)
      CMD_ADD: begin
        if (mdl_count < MaxInf) begin
          append_entry(req.joint_index, req.new_weight);
          queue_rsp(make_rsp(RS_APPENDED, '0, '0, 1'b1));
        end else begin
          min_pos = 0;
          min_w   = mdl_weight[0];
          for (int i = 1; i < mdl_count; i++) begin
            if (mdl_weight[i] < min_w) begin
              min_w   = mdl_weight[i];
              min_pos = i;
            end
          end
          if (req.new_weight > min_w) begin
            remove_entry(min_pos);
            append_entry(req.joint_index, req.new_weight);
            queue_rsp(make_rsp(RS_REPLACED, '0, '0, 1'b1));
          end else begin
            queue_rsp(make_rsp(RS_REJECTED, '0, '0, 1'b1));
          end
        end
      end
      CMD_ERASE: begin
        found = 1'b0;
        for (int i = 0; i < mdl_count && !found; i++) begin
          if (mdl_joint[i] == req.joint_index) begin
            remove_entry(i);
            found = 1'b1;
          end
        end
        queue_rsp(make_rsp(found ? RS_ERASED : RS_NOTFOUND, '0, '0, 1'b1));
      end
      CMD_NORM: begin
        if (mdl_count == 0) begin
          queue_rsp(make_rsp(RS_EMPTY, '0, '0, 1'b1));
        end else begin
          weight_sum = '0;
          for (int i = 0; i < mdl_count; i++) weight_sum += mdl_weight[i];
          for (int i = 0; i < mdl_count; i++) begin
            if (weight_sum != 0) begin
              quo           = {1'b0, mdl_weight[i], 15'd0} / {14'd0, weight_sum};
              mdl_weight[i] = quo[DataW-1:0];
            end
            queue_rsp(make_rsp(RS_NORMED, mdl_joint[i], mdl_weight[i],
                               i + 1 == mdl_count));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // The request is offered at the current edge and counts as accepted at the
  // first later edge that sees the stall low.
  task automatic send_req(input logic [1:0] cmd, input logic [DataW-1:0] joint,
                          input logic [DataW-1:0] weight);
    in_req_t req;
    req.command     = cmd;
    req.joint_index = joint;
    req.new_weight  = weight;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_table_rsp(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_all_rsp();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (table_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic clear_table();
    while (mdl_count > 0) send_req(CMD_ERASE, mdl_joint[0], DataW'($urandom));
  endtask

  task automatic test_empty_table();
    send_req(CMD_NORM, 16'hFFFF, 16'hFFFF);
    send_req(CMD_ERASE, 16'h0000, 16'h0000);
  endtask

  // Covers rejection on an equal weight and the lowest position winning a tie.
  task automatic test_fill_and_replace();
    send_req(CMD_ADD, 16'h0000, 16'h0000);
    send_req(CMD_ADD, 16'hFFFF, 16'hFFFF);
    send_req(CMD_ADD, 16'h1234, 16'h0001);
    send_req(CMD_ADD, 16'hAAAA, 16'h5555);
    send_req(CMD_ADD, 16'hBEEF, 16'h0000);
    send_req(CMD_ADD, 16'h5A5A, 16'h0001);
    send_req(CMD_ADD, 16'h0007, 16'h0002);
    send_req(CMD_ADD, 16'h8000, 16'h0001);
  endtask

  task automatic test_normalize();
    send_req(CMD_NORM, 16'h0000, 16'h0000);
  endtask

  task automatic test_erase();
    send_req(CMD_ERASE, 16'hAAAA, 16'h0000);
    send_req(CMD_ERASE, 16'h1111, 16'hFFFF);
    clear_table();
    send_req(CMD_ADD, 16'h0033, 16'h000A);
    send_req(CMD_ADD, 16'h0033, 16'h0014);
    send_req(CMD_ERASE, 16'h0033, 16'h0000);
    send_req(CMD_NORM, 16'h0000, 16'h0000);
  endtask

  task automatic test_zero_sum();
    clear_table();
    send_req(CMD_ADD, 16'h0001, 16'h0000);
    send_req(CMD_ADD, 16'h0002, 16'h0000);
    send_req(CMD_NORM, 16'h0000, 16'h0000);
  endtask

  task automatic test_max_sum();
    clear_table();
    for (int i = 0; i < MaxInf; i++) send_req(CMD_ADD, DataW'(i), 16'hFFFF);
    send_req(CMD_NORM, 16'h0000, 16'h0000);
  endtask

  task automatic test_unused_command();
    send_req(CmdUnused, DataW'($urandom), DataW'($urandom));
    send_req(CMD_NORM, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_mix(input int unsigned n_req);
    int unsigned      sent;
    int unsigned      pick;
    logic [1:0]       cmd;
    logic [DataW-1:0] joint;
    logic [DataW-1:0] weight;
    sent = 0;
    while (sent < n_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = CMD_ADD;
      else if (pick < 70) cmd = CMD_ERASE;
      else if (pick < 95) cmd = CMD_NORM;
      else                cmd = CmdUnused;
      if (cmd == CMD_ERASE && mdl_count > 0 && $urandom_range(0, 3) != 0) begin
        joint = mdl_joint[$urandom_range(0, mdl_count - 1)];
      end else if ($urandom_range(0, 1) == 0) begin
        joint = DataW'($urandom_range(0, 7));
      end else begin
        joint = DataW'($urandom);
      end
      case ($urandom_range(0, 3))
        0:       weight = DataW'($urandom_range(0, 3));
        1:       weight = DataW'($urandom_range(0, 255));
        default: weight = DataW'($urandom);
      endcase
      send_req(cmd, joint, weight);
      if (cmd != CmdUnused) sent++;
    end
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 12; i++) begin
      send_req(($urandom_range(0, 2) == 0) ? CMD_NORM : CMD_ADD,
               DataW'($urandom_range(0, 7)), DataW'($urandom));
    end
    wait_all_rsp();
  endtask

  initial begin : rsp_stall_gen
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_seen;
    int unsigned hold_left;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
          default:     out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [DataW-1:0] exp_v,
                             input logic [DataW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (table_rsp_q.size() == 0) begin
        $error("response with status %0d and no request waiting", out_rsp_o.status);
        err_cnt++;
      end else begin
        exp_rsp = table_rsp_q.pop_front();
        check_field("status", DataW'(exp_rsp.status), DataW'(out_rsp_o.status));
        check_field("joint_out", exp_rsp.joint_out, out_rsp_o.joint_out);
        check_field("weight_out", exp_rsp.weight_out, out_rsp_o.weight_out);
        check_field("entry_count", DataW'(exp_rsp.entry_count),
                    DataW'(out_rsp_o.entry_count));
        check_field("last", DataW'(exp_rsp.last), DataW'(out_rsp_o.last));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_seq
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_and_replace();
    test_normalize();
    test_erase();
    test_zero_sum();
    test_max_sum();
    test_unused_command();
    test_random_mix(100);
    test_backpressure();
    test_random_mix(100);
    wait_all_rsp();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && table_rsp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (table_rsp_q.size() != 0) $error("%0d responses never arrived", table_rsp_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/sit4_pkg.sv
rtl/core/sit4_datapath.sv
rtl/core/sit4_controller.sv
rtl/core/skin_influence_top4_table.sv
tb/tb.sv
